// File: hw/rtl/ssc_pkg.sv
// Shared types, constants and helpers of the segment/sphere collision core.
// Used by every module of the core and by its checker; depends on nothing.
`default_nettype none

package ssc_pkg;

	localparam int SQRT_STEPS = 32;  // one root bit per stage, 64-bit radicand
	localparam int DIV_STEPS  = 17;  // unit components stay within +/-1.0
	localparam int MQ_DEPTH   = 4;   // queue between front and back (power of two)
	localparam int OQ_DEPTH   = 2;   // result queue (power of two)

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic        [30:0] radius_sq;
	} ssc_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [30:0] penetration;
	} ssc_out_t;

	typedef struct packed {
		ssc_in_t     item;
		logic [31:0] len;
	} ssc_mid_t;

	typedef enum logic [1:0] {
		PT_START,
		PT_END,
		PT_MID
	} pt_sel_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] mul32u(input logic [31:0] a, input logic [31:0] b);
		return {32'd0, a} * {32'd0, b};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssc_front.sv
// Front part: segment direction, squared length and a 32-stage floor square root.
// Depends on ssc_pkg; feeds ssc_queue.
`default_nettype none

module ssc_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  ssc_pkg::ssc_in_t item,
	output logic             q_push,
	output ssc_pkg::ssc_mid_t q_data,
	input  wire              q_full
);
	import ssc_pkg::*;

	localparam int NS = SQRT_STEPS;

	logic        adv;
	logic        v_s1, v_s2;
	ssc_in_t     itm_s1, itm_s2;
	logic [31:0] mag_s1 [0:2];
	logic [63:0] sq_s2  [0:2];
	logic [31:0] mag_c  [0:2];

	// root pipeline; index 0 holds the radicand
	logic        sv_s    [0:NS];
	ssc_in_t     sitm_s  [0:NS];
	logic [63:0] sn_s    [0:NS];
	logic [33:0] srem_s  [0:NS];
	logic [31:0] sroot_s [0:NS];
	logic [33:0] rem_n   [1:NS];
	logic [31:0] root_n  [1:NS];

	assign adv    = !(sv_s[NS] && q_full);
	assign full   = !adv;
	assign q_push = sv_s[NS] && !q_full;
	assign q_data = '{item: sitm_s[NS], len: sroot_s[NS]};

	always_comb begin
		mag_c[0] = mag32(32'(item.end_x - item.start_x));
		mag_c[1] = mag32(32'(item.end_y - item.start_y));
		mag_c[2] = mag32(32'(item.end_z - item.start_z));
	end

	always_comb begin
		logic [35:0] cand;
		logic [35:0] trial;
		for (int k = 1; k <= NS; k++) begin
			cand  = {srem_s[k-1], sn_s[k-1][63:62]};
			trial = {2'b00, sroot_s[k-1], 2'b01};
			if (cand >= trial) begin
				rem_n[k]  = 34'(cand - trial);
				root_n[k] = {sroot_s[k-1][30:0], 1'b1};
			end else begin
				rem_n[k]  = cand[33:0];
				root_n[k] = {sroot_s[k-1][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= NS; k++) sv_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1    <= push;
			v_s2    <= v_s1;
			sv_s[0] <= v_s2;
			for (int k = 1; k <= NS; k++) sv_s[k] <= sv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_s1 <= item;
			itm_s2 <= itm_s1;
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				sq_s2[i]  <= mul32u(mag_s1[i], mag_s1[i]);
			end
			sitm_s[0]  <= itm_s2;
			sn_s[0]    <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			srem_s[0]  <= '0;
			sroot_s[0] <= '0;
			for (int k = 1; k <= NS; k++) begin
				sitm_s[k]  <= sitm_s[k-1];
				sn_s[k]    <= {sn_s[k-1][61:0], 2'b00};
				srem_s[k]  <= rem_n[k];
				sroot_s[k] <= root_n[k];
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssc_queue.sv
// Short register queue between the front and back parts.
// Depends on ssc_pkg for the entry type and depth.
`default_nettype none

module ssc_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  ssc_pkg::ssc_mid_t din,
	input  wire               pop,
	output logic              empty,
	output ssc_pkg::ssc_mid_t dout
);
	import ssc_pkg::*;

	localparam int PW = $clog2(MQ_DEPTH);

	ssc_mid_t     entries [0:MQ_DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(MQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries[wr_q] <= din;
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssc_back.sv
// Back part: unit direction divider, projection, clamp, squared distance, result queue.
// Depends on ssc_pkg; fed from ssc_queue.
`default_nettype none

module ssc_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_empty,
	input  ssc_pkg::ssc_mid_t q_data,
	output logic              q_pop,
	output logic              empty,
	input  wire               pop,
	output ssc_pkg::ssc_out_t result
);
	import ssc_pkg::*;

	localparam int DS  = DIV_STEPS;
	localparam int OPW = $clog2(OQ_DEPTH);

	logic adv;

	// divider pipeline; index 0 is the entry stage
	logic               dv_s   [0:DS];
	ssc_mid_t           dmid_s [0:DS];
	logic signed [31:0] dv0_s  [0:DS][0:2];
	logic               dneg_s [0:DS][0:2];
	logic               dlsb_s [0:DS][0:2];
	logic        [31:0] drem_s [0:DS][0:2];
	logic        [16:0] dq_s   [0:DS][0:2];
	logic        [31:0] rem_n  [1:DS][0:2];
	logic        [16:0] q_n    [1:DS][0:2];

	logic signed [31:0] dir_c [0:2];
	logic signed [31:0] v0_c  [0:2];
	logic        [31:0] mag_c [0:2];

	logic               v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ssc_mid_t           mid_s2, mid_s3, mid_s4, mid_s5;
	logic signed [31:0] v0_s2 [0:2];
	logic signed [17:0] unit_s2 [0:2], unit_s3 [0:2], unit_s4 [0:2];
	logic signed [49:0] prod_s3 [0:2];
	logic signed [35:0] t_s4;
	pt_sel_t            sel_s5;
	logic signed [50:0] prod2_s5 [0:2];
	logic signed [31:0] p_s6 [0:2], p_s7 [0:2], p_s8 [0:2];
	logic signed [31:0] c_s6 [0:2];
	logic        [30:0] rsq_s6, rsq_s7, rsq_s8;
	logic        [31:0] dmag_s7 [0:2];
	logic        [63:0] dsq_s8 [0:2];
	ssc_out_t           res_s9;

	logic signed [17:0] unit_c [0:2];
	logic signed [35:0] t_c;
	pt_sel_t            sel_c;
	logic signed [50:0] prod2_c [0:2];
	logic signed [31:0] s_c [0:2], e_c [0:2], cc_c [0:2], p_c [0:2];
	ssc_out_t           res_c;

	ssc_out_t      oq [0:OQ_DEPTH-1];
	logic [OPW-1:0] owr_q, ord_q;
	logic [OPW:0]   ocnt_q;
	logic           o_push, o_pop;

	assign adv    = !v_s9 || (ocnt_q != (OPW+1)'(OQ_DEPTH));
	assign q_pop  = adv && !q_empty;
	assign o_push = adv && v_s9;
	assign o_pop  = pop && !empty;
	assign empty  = (ocnt_q == '0);
	assign result = oq[ord_q];

	// entry: direction and start-to-centre vectors
	always_comb begin
		dir_c[0] = q_data.item.end_x - q_data.item.start_x;
		dir_c[1] = q_data.item.end_y - q_data.item.start_y;
		dir_c[2] = q_data.item.end_z - q_data.item.start_z;
		v0_c[0]  = q_data.item.center_x - q_data.item.start_x;
		v0_c[1]  = q_data.item.center_y - q_data.item.start_y;
		v0_c[2]  = q_data.item.center_z - q_data.item.start_z;
		for (int i = 0; i < 3; i++) mag_c[i] = mag32(dir_c[i]);
	end

	// restoring division of |dir| * 2^16 by len, one quotient bit per stage
	always_comb begin
		logic [32:0] cand;
		for (int k = 1; k <= DS; k++) begin
			for (int i = 0; i < 3; i++) begin
				cand = {drem_s[k-1][i], (k == 1) ? dlsb_s[k-1][i] : 1'b0};
				if (cand >= {1'b0, dmid_s[k-1].len}) begin
					rem_n[k][i] = 32'(cand - {1'b0, dmid_s[k-1].len});
					q_n[k][i]   = {dq_s[k-1][i][15:0], 1'b1};
				end else begin
					rem_n[k][i] = cand[31:0];
					q_n[k][i]   = {dq_s[k-1][i][15:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		logic signed [17:0] u;
		for (int i = 0; i < 3; i++) begin
			u = {1'b0, dq_s[DS][i]};
			if (dmid_s[DS].len == '0) unit_c[i] = '0;
			else                      unit_c[i] = dneg_s[DS][i] ? 18'(-u) : u;
		end
	end

	assign t_c = 36'(prod_s3[0] >>> 16) + 36'(prod_s3[1] >>> 16) + 36'(prod_s3[2] >>> 16);

	// clamp the projection to the segment
	always_comb begin
		if (t_s4[35])                                  sel_c = PT_START;
		else if (t_s4[34:0] >= {3'b000, mid_s4.len})   sel_c = PT_END;
		else                                           sel_c = PT_MID;
		for (int i = 0; i < 3; i++)
			prod2_c[i] = $signed({1'b0, t_s4[31:0]}) * unit_s4[i];
	end

	always_comb begin
		s_c[0]  = mid_s5.item.start_x;
		s_c[1]  = mid_s5.item.start_y;
		s_c[2]  = mid_s5.item.start_z;
		e_c[0]  = mid_s5.item.end_x;
		e_c[1]  = mid_s5.item.end_y;
		e_c[2]  = mid_s5.item.end_z;
		cc_c[0] = mid_s5.item.center_x;
		cc_c[1] = mid_s5.item.center_y;
		cc_c[2] = mid_s5.item.center_z;
		for (int i = 0; i < 3; i++) begin
			case (sel_s5)
				PT_START: p_c[i] = s_c[i];
				PT_END:   p_c[i] = e_c[i];
				PT_MID:   p_c[i] = s_c[i] + prod2_s5[i][47:16];
				default:  p_c[i] = s_c[i];
			endcase
		end
	end

	// squared distance, saturated, against the squared radius
	always_comb begin
		logic [63:0] acc;
		logic [30:0] sq_dist;
		acc     = dsq_s8[0] + dsq_s8[1] + dsq_s8[2];
		sq_dist = (|acc[63:47]) ? 31'h7FFF_FFFF : acc[46:16];
		if (sq_dist < rsq_s8) begin
			res_c.hit         = 1'b1;
			res_c.point_x     = p_s8[0];
			res_c.point_y     = p_s8[1];
			res_c.point_z     = p_s8[2];
			res_c.penetration = sq_dist;
		end else begin
			res_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DS; k++) dv_s[k] <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= !q_empty;
			for (int k = 1; k <= DS; k++) dv_s[k] <= dv_s[k-1];
			v_s2 <= dv_s[DS];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmid_s[0] <= q_data;
			for (int i = 0; i < 3; i++) begin
				dv0_s[0][i]  <= v0_c[i];
				dneg_s[0][i] <= dir_c[i][31];
				dlsb_s[0][i] <= mag_c[i][0];
				drem_s[0][i] <= {1'b0, mag_c[i][31:1]};
				dq_s[0][i]   <= '0;
			end
			for (int k = 1; k <= DS; k++) begin
				dmid_s[k] <= dmid_s[k-1];
				for (int i = 0; i < 3; i++) begin
					dv0_s[k][i]  <= dv0_s[k-1][i];
					dneg_s[k][i] <= dneg_s[k-1][i];
					dlsb_s[k][i] <= dlsb_s[k-1][i];
					drem_s[k][i] <= rem_n[k][i];
					dq_s[k][i]   <= q_n[k][i];
				end
			end
			mid_s2 <= dmid_s[DS];
			mid_s3 <= mid_s2;
			mid_s4 <= mid_s3;
			mid_s5 <= mid_s4;
			t_s4   <= t_c;
			sel_s5 <= sel_c;
			for (int i = 0; i < 3; i++) begin
				v0_s2[i]    <= dv0_s[DS][i];
				unit_s2[i]  <= unit_c[i];
				unit_s3[i]  <= unit_s2[i];
				unit_s4[i]  <= unit_s3[i];
				prod_s3[i]  <= v0_s2[i] * unit_s2[i];
				prod2_s5[i] <= prod2_c[i];
				p_s6[i]     <= p_c[i];
				c_s6[i]     <= cc_c[i];
				p_s7[i]     <= p_s6[i];
				dmag_s7[i]  <= mag32(p_s6[i] - c_s6[i]);
				p_s8[i]     <= p_s7[i];
				dsq_s8[i]   <= mul32u(dmag_s7[i], dmag_s7[i]);
			end
			rsq_s6 <= mid_s5.item.radius_sq;
			rsq_s7 <= rsq_s6;
			rsq_s8 <= rsq_s7;
			res_s9 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (o_push) owr_q <= owr_q + 1'b1;
			if (o_pop)  ord_q <= ord_q + 1'b1;
			case ({o_push, o_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (o_push) oq[owr_q] <= res_s9;
	end

endmodule

`default_nettype wire

// File: hw/rtl/segment_sphere_collision_core.sv
// Segment versus sphere test, Q16.16: closest segment point and squared distance.
// Throughput: one item per cycle, sustained by the 32-stage square root in the front
// and the 17-stage divider per axis in the back; each part stalls only on its own queue.
// Reset: asynchronous, clears all valid bits and queue pointers; no clearing pass.
// Depends on ssc_pkg, ssc_front, ssc_queue and ssc_back.
`default_nettype none

module segment_sphere_collision_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  ssc_pkg::ssc_in_t  item,
	output logic              empty,
	input  wire               pop,
	output ssc_pkg::ssc_out_t result
);
	import ssc_pkg::*;

	logic     mq_push, mq_full, mq_pop, mq_empty;
	ssc_mid_t mq_din, mq_dout;

	ssc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (mq_push),
		.q_data (mq_din),
		.q_full (mq_full)
	);

	ssc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.full   (mq_full),
		.din    (mq_din),
		.pop    (mq_pop),
		.empty  (mq_empty),
		.dout   (mq_dout)
	);

	ssc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (mq_empty),
		.q_data  (mq_dout),
		.q_pop   (mq_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ssc_check.sv
// Port-level checker for segment_sphere_collision_core, attached by bind.
// Depends on ssc_pkg for the payload types.
`default_nettype none

module ssc_check (
	input wire               clk,
	input wire               arst_n,
	input wire               empty,
	input wire               pop,
	input ssc_pkg::ssc_out_t result
);
	import ssc_pkg::*;

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.hit) |-> (result.point_x == '0 && result.point_y == '0 &&
		                             result.point_z == '0 && result.penetration == '0))
		else $error("miss with nonzero payload");

	// a hit is strictly inside a radius of at most full scale, so never saturated
	a_hit_unsat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.hit) |-> (result.penetration != 31'h7FFF_FFFF))
		else $error("hit with saturated distance");

	// nothing can come out right after reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result shown right after reset");

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind segment_sphere_collision_core ssc_check u_check (.*);

`default_nettype wire
